[rtl/yccrop_pkg.sv]
package yccrop_pkg;

    // register file
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_W  = 2'd0,
        CFG_SRC_H  = 2'd1,
        CFG_CROP_W = 2'd2,
        CFG_CROP_H = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_SRC_W  = 13'd640;
    localparam logic [CFG_W-1:0] RST_SRC_H  = 13'd480;
    localparam logic [CFG_W-1:0] RST_CROP_W = 13'd640;
    localparam logic [CFG_W-1:0] RST_CROP_H = 13'd480;

    // bt.601 fixed point, scaled by 256
    localparam int SUM_W = 20;
    localparam logic signed [SUM_W-1:0] K_Y    = 20'sd298;
    localparam logic signed [SUM_W-1:0] K_RV   = 20'sd409;
    localparam logic signed [SUM_W-1:0] K_GU   = 20'sd100;
    localparam logic signed [SUM_W-1:0] K_GV   = 20'sd208;
    localparam logic signed [SUM_W-1:0] K_BU   = 20'sd516;
    localparam logic signed [SUM_W-1:0] K_RND  = 20'sd128;
    localparam logic signed [8:0]       Y_OFS  = 9'sd16;
    localparam logic signed [8:0]       C_OFS  = 9'sd128;
    localparam logic [7:0]              CH_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] chroma_red;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic [7:0] luma_first;
    } t_pair;

    typedef struct packed {
        logic [15:0] rgb_second;
        logic [15:0] rgb_first;
    } t_rgb_pair;

    // window decision for the current source position
    typedef struct packed {
        logic keep;
        logic last;
    } t_tag;

    function automatic logic signed [SUM_W-1:0] sext9(input logic signed [8:0] x);
        return {{(SUM_W-9){x[8]}}, x};
    endfunction

    // clamp a scaled channel sum to 0..255 after the floor shift
    function automatic logic [7:0] chan(input logic signed [SUM_W-1:0] t);
        logic [7:0] c;
        if (t[SUM_W-1]) begin
            c = 8'd0;
        end else if (t[SUM_W-2:16] != '0) begin
            c = CH_MAX;
        end else begin
            c = t[15:8];
        end
        return c;
    endfunction

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

[rtl/yccrop_window.sv]
module yccrop_window #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [yccrop_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [yccrop_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                               i_accept,
    output logic                               o_busy,
    output yccrop_pkg::t_tag                   o_tag
);
    import yccrop_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int GW    = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int XW    = GW + 1;
    localparam int PCW   = $clog2(MAX_DIMENSION / 2);
    localparam int LW    = $clog2(MAX_DIMENSION);

    logic [CFG_W-1:0] r_src_w, r_src_h, r_crop_w, r_crop_h;
    logic             r_busy;
    logic [PCW-1:0]   r_col, n_col;
    logic [LW-1:0]    r_line, n_line;

    // registered window geometry
    logic          r_en;
    logic [XW-1:0] r_x0, r_xe, r_y0, r_ye, r_pairs, r_sh;

    logic [XW-1:0] sw, sh, cw, ch;
    logic [XW-1:0] col_x, line_x, col_inc, line_inc;

    function automatic logic [XW-1:0] sat(input logic [CFG_W-1:0] v);
        logic [XW-1:0] e;
        e = XW'(v);
        return (e > XW'(MAX_DIMENSION)) ? XW'(MAX_DIMENSION) : e;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= RST_SRC_W;
            r_src_h  <= RST_SRC_H;
            r_crop_w <= RST_CROP_W;
            r_crop_h <= RST_CROP_H;
            r_busy   <= 1'b1;
        end else begin
            r_busy <= i_cfg_we;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SRC_W:  r_src_w  <= i_cfg_data;
                    CFG_SRC_H:  r_src_h  <= i_cfg_data;
                    CFG_CROP_W: r_crop_w <= i_cfg_data;
                    CFG_CROP_H: r_crop_h <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        sw = sat(r_src_w) & ~XW'(1);
        if (sw < XW'(2)) begin
            sw = XW'(2);
        end
        sh = sat(r_src_h);
        if (sh == '0) begin
            sh = XW'(1);
        end
        cw = sat(r_crop_w) & ~XW'(1);
        ch = sat(r_crop_h);
    end

    // x end = x0 + crop pairs folds into one add, same for y
    always_ff @(posedge i_clk) begin
        r_en    <= (cw != '0) && (ch != '0) && (cw <= sw) && (ch <= sh);
        r_x0    <= (sw - cw) >> 2;
        r_xe    <= (sw + cw) >> 2;
        r_y0    <= (sh - ch) >> 1;
        r_ye    <= (sh + ch) >> 1;
        r_pairs <= sw >> 1;
        r_sh    <= sh;
    end

    assign col_x    = XW'(r_col);
    assign line_x   = XW'(r_line);
    assign col_inc  = col_x + XW'(1);
    assign line_inc = line_x + XW'(1);

    assign o_tag.keep = r_en && (col_x >= r_x0) && (col_x < r_xe)
                        && (line_x >= r_y0) && (line_x < r_ye);
    assign o_tag.last = (col_inc == r_xe) && (line_inc == r_ye);
    assign o_busy     = r_busy;

    always_comb begin
        n_col  = r_col;
        n_line = r_line;
        if (col_inc >= r_pairs) begin
            n_col  = '0;
            n_line = (line_inc >= r_sh) ? '0 : LW'(line_inc);
        end else begin
            n_col = PCW'(col_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= '0;
        end else if (i_accept) begin
            r_col  <= n_col;
            r_line <= n_line;
        end
    end

endmodule

[rtl/yccrop_convert.sv]
module yccrop_convert (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  yccrop_pkg::t_pair       i_pair,
    input  logic                    i_last,
    output logic                    o_valid,
    input  logic                    i_ready,
    output yccrop_pkg::t_rgb_pair   o_rgb,
    output logic                    o_last
);
    import yccrop_pkg::*;

    logic signed [8:0] c1, c2, d, e;
    logic              out_en, prod_en;

    // product stage
    logic                    r_p_v;
    logic                    r_p_last;
    logic signed [SUM_W-1:0] r_y1, r_y2, r_cr, r_cg, r_cb;

    // result register
    logic                    r_out_v;
    logic                    r_out_last;
    t_rgb_pair               r_out_rgb;

    logic signed [SUM_W-1:0] r1, g1, b1, r2, g2, b2;

    assign c1 = $signed({1'b0, i_pair.luma_first})  - Y_OFS;
    assign c2 = $signed({1'b0, i_pair.luma_second}) - Y_OFS;
    assign d  = $signed({1'b0, i_pair.chroma_blue}) - C_OFS;
    assign e  = $signed({1'b0, i_pair.chroma_red})  - C_OFS;

    assign out_en  = !r_out_v || i_ready;
    assign prod_en = !r_p_v || out_en;
    assign o_ready = prod_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (prod_en) begin
            r_p_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (prod_en && i_valid) begin
            r_p_last <= i_last;
            r_y1     <= sext9(c1) * K_Y;
            r_y2     <= sext9(c2) * K_Y;
            r_cr     <= sext9(e) * K_RV + K_RND;
            r_cg     <= K_RND - sext9(d) * K_GU - sext9(e) * K_GV;
            r_cb     <= sext9(d) * K_BU + K_RND;
        end
    end

    assign r1 = r_y1 + r_cr;
    assign g1 = r_y1 + r_cg;
    assign b1 = r_y1 + r_cb;
    assign r2 = r_y2 + r_cr;
    assign g2 = r_y2 + r_cg;
    assign b2 = r_y2 + r_cb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_en) begin
            r_out_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_p_v) begin
            r_out_last           <= r_p_last;
            r_out_rgb.rgb_first  <= pack565(chan(r1), chan(g1), chan(b1));
            r_out_rgb.rgb_second <= pack565(chan(r2), chan(g2), chan(b2));
        end
    end

    assign o_valid = r_out_v;
    assign o_rgb   = r_out_rgb;
    assign o_last  = r_out_last;

endmodule

[rtl/yuv422_center_crop_to_rgb565_unit.sv]
// channel    | direction | transaction moves                  | handshake
// -----------+-----------+------------------------------------+-------------------------
// s stream   | in        | one yuyv pixel pair                | i_s_tvalid / o_s_tready
// m stream   | out       | two rgb565 pixels, tlast = frame end| o_m_tvalid / i_m_tready
// cfg write  | in        | register index and 13-bit value    | i_cfg_valid / o_cfg_ready
//
// one pair per clock sustained while the master side is ready and no register write is settling;
// a kept pair passes the input register, product stage and result register, in that order
// every stage has its own valid bit, so bubbles fill while the output is stalled
// synchronous active-low reset; the input side stays low for one cycle after reset
// and for one cycle after each register write while the crop geometry re-registers
module yuv422_center_crop_to_rgb565_unit #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [31:0]                        i_s_tdata,   // luma_first, chroma_blue,
                                                            // luma_second, chroma_red
    // master stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [31:0]                        o_m_tdata,   // rgb_first, rgb_second
    output logic                               o_m_tlast,   // frame_last
    // register write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [yccrop_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [yccrop_pkg::CFG_W-1:0]       i_cfg_data
);
    import yccrop_pkg::*;

    logic      s_accept, cfg_accept;
    logic      w_busy;
    t_tag      w_tag;
    logic      in_en;
    logic      conv_ready;
    t_rgb_pair w_rgb;

    // input register, valid only for pairs inside the crop window
    logic      r_in_v;
    t_pair     r_in_pair;
    logic      r_in_last;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;

    // the input register frees when the conversion pipe can take its pair
    assign in_en      = !r_in_v || conv_ready;
    assign o_s_tready = in_en && !w_busy;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // position counters and window decision
    yccrop_window #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_accept),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (s_accept),
        .o_busy      (w_busy),
        .o_tag       (w_tag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_en) begin
            r_in_v <= s_accept && w_tag.keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_pair <= t_pair'(i_s_tdata);
            r_in_last <= w_tag.last;
        end
    end

    // colour conversion and result register
    yccrop_convert u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .o_ready (conv_ready),
        .i_pair  (r_in_pair),
        .i_last  (r_in_last),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_rgb   (w_rgb),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = w_rgb;

    // geometry is stale in the cycle after a write, so no pair may enter then
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_s_tready)
        else $error("pair accepted while crop geometry is settling");

    a_cfg_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_accept |=> !o_s_tready)
        else $error("input ready right after a register write");

    a_kept_pair_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && w_tag.keep) |=> r_in_v)
        else $error("kept pair lost at the input register");

endmodule
